>>> hw/rtl/lbm_pkg.sv
// Shared types and constants of the lightmap bilinear modulate block.
// No dependencies; every other file but lbm_div imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lbm_pkg;

    // texel store
    localparam int TEX_DEPTH = 16384;
    localparam int TEX_AW    = $clog2(TEX_DEPTH);
    localparam int TEXEL_W   = 24;

    // field and register widths
    localparam int LS_W  = 8;   // lightmap side
    localparam int AS_W  = 13;  // albedo side register
    localparam int PX_W  = 12;  // pixel coordinate
    localparam int WF    = 8;   // weight fraction bits
    localparam int MAX_ALBEDO_SIDE = 4096;

    // coordinate mapping: q = ((2p+1)*lsz << (WF-1)) / asz
    localparam int NUM_W = PX_W + 1 + LS_W;
    localparam int QW    = NUM_W + WF - 1;
    localparam int HI_W  = QW - WF;

    // commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MOD  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_LM_W = 2'd0;
    localparam logic [1:0] CFG_LM_H = 2'd1;
    localparam logic [1:0] CFG_AL_W = 2'd2;
    localparam logic [1:0] CFG_AL_H = 2'd3;

    // neighbor taps in a task
    localparam int TAP_00 = 0;
    localparam int TAP_10 = 1;
    localparam int TAP_01 = 2;
    localparam int TAP_11 = 3;

    typedef struct packed {
        logic              cmd;
        logic [TEX_AW-1:0] texel_index;
        logic [PX_W-1:0]   pixel_x;
        logic [PX_W-1:0]   pixel_y;
        logic [7:0]        in_red;
        logic [7:0]        in_green;
        logic [7:0]        in_blue;
        logic [7:0]        in_alpha;
    } t_in_item;

    typedef struct packed {
        logic [PX_W-1:0] out_x;
        logic [PX_W-1:0] out_y;
        logic [7:0]      out_red;
        logic [7:0]      out_green;
        logic [7:0]      out_blue;
        logic [7:0]      out_alpha;
    } t_out_item;

    typedef struct packed {
        logic [LS_W-1:0] lm_w;
        logic [LS_W-1:0] lm_h;
        logic [AS_W-1:0] al_w;
        logic [AS_W-1:0] al_h;
    } t_cfg;

    // classified item handed from the front to the back
    typedef struct packed {
        logic                   cmd;
        logic                   bypass;
        logic [3:0][TEX_AW-1:0] addr;
        logic [WF-1:0]          frac_x;
        logic [WF-1:0]          frac_y;
        logic [PX_W-1:0]        pixel_x;
        logic [PX_W-1:0]        pixel_y;
        logic [7:0]             red;
        logic [7:0]             green;
        logic [7:0]             blue;
        logic [7:0]             alpha;
    } t_task;

endpackage

`default_nettype wire

>>> hw/rtl/lightmap_bilinear_modulate.sv
// Top level of the lightmap bilinear modulate block: configuration registers,
// front end, task queue and back end. Uses lbm_pkg, lbm_front, lbm_queue, lbm_back.
//
//  channel  direction  handshake                  payload
//  in       sink       i_in_valid / o_in_ready    i_in_data  (t_in_item)
//  out      source     o_out_valid / i_out_ready  o_out_data (t_out_item)
//  cfg      sink       i_cfg_wr_en                i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output does not stall; load items update
// the store, modulate items give one pixel. Items pass through the two divider pipelines
// (28 quotient stages, 20 wrap stages), the address stage, the queue and five
// back-end stages. Reset clears control state only; the texel store has no
// clearing pass. An output stall fills the queue, then holds the front end.
`timescale 1ns / 1ps
`default_nettype none

module lightmap_bilinear_modulate import lbm_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in_item        i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out_item       o_out_data,
    input  logic            i_cfg_wr_en,
    input  logic [1:0]      i_cfg_index,
    input  logic [AS_W-1:0] i_cfg_data
);

    t_cfg            r_cfg;
    logic [AS_W-1:0] w_side;
    logic            w_push;
    t_task           w_push_task;
    logic            w_full;
    logic            w_q_valid;
    t_task           w_q_task;
    logic            w_pop;

    // clamp albedo sides to the largest supported image
    assign w_side = (i_cfg_data > AS_W'(MAX_ALBEDO_SIDE)) ? AS_W'(MAX_ALBEDO_SIDE)
                                                          : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lm_w <= '0;
            r_cfg.lm_h <= '0;
            r_cfg.al_w <= AS_W'(1);
            r_cfg.al_h <= AS_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LM_W: begin
                    r_cfg.lm_w <= i_cfg_data[LS_W-1:0];
                end
                CFG_LM_H: begin
                    r_cfg.lm_h <= i_cfg_data[LS_W-1:0];
                end
                CFG_AL_W: begin
                    r_cfg.al_w <= w_side;
                end
                CFG_AL_H: begin
                    r_cfg.al_h <= w_side;
                end
                default: begin
                end
            endcase
        end
    end

    lbm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_data),
        .o_push  (w_push),
        .o_task  (w_push_task),
        .i_full  (w_full)
    );

    lbm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_task),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_task)
    );

    lbm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_task  (w_q_task),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

endmodule

`default_nettype wire

>>> hw/rtl/lbm_div.sv
// Pipelined restoring divider, one quotient bit per stage, NW stages.
// Depends on nothing; the divisor must hold while items are in flight.
`timescale 1ns / 1ps
`default_nettype none

module lbm_div #(
    parameter int NW = 28,
    parameter int DW = 13
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_nq  [NW];
    logic [DW-1:0] n_rem [NW];
    logic [NW-1:0] n_nq  [NW];

    always_comb begin : c_stage
        logic [DW:0]   v_trial;
        logic [NW-1:0] v_nq;
        v_trial = {{DW{1'b0}}, i_num[NW-1]};
        if (v_trial >= {1'b0, i_den}) begin
            n_rem[0] = DW'(v_trial - {1'b0, i_den});
            n_nq[0]  = {i_num[NW-2:0], 1'b1};
        end else begin
            n_rem[0] = v_trial[DW-1:0];
            n_nq[0]  = {i_num[NW-2:0], 1'b0};
        end
        for (int k = 1; k < NW; k++) begin
            v_nq    = r_nq[k-1];
            v_trial = {r_rem[k-1], v_nq[NW-1]};
            if (v_trial >= {1'b0, i_den}) begin
                n_rem[k] = DW'(v_trial - {1'b0, i_den});
                n_nq[k]  = {v_nq[NW-2:0], 1'b1};
            end else begin
                n_rem[k] = v_trial[DW-1:0];
                n_nq[k]  = {v_nq[NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NW; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
            end
        end
    end

    assign o_quo = r_nq[NW-1];
    assign o_rem = r_rem[NW-1];

endmodule

`default_nettype wire

>>> hw/rtl/lbm_front.sv
// Front end: takes items, maps pixel centers onto the lightmap, wraps the
// neighbor coordinates and forms four store addresses (a load's TAP_00 is its texel index). Uses lbm_pkg, lbm_div.
`timescale 1ns / 1ps
`default_nettype none

module lbm_front import lbm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_push,
    output t_task    o_task,
    input  logic     i_full
);

    // input stage, quotient stages, wrap stages
    localparam int PL_LEN = 1 + QW + HI_W;

    logic              w_en;
    logic [PL_LEN-1:0] r_vld;
    t_in_item          r_pl [PL_LEN];
    logic [WF-1:0]     r_fx [HI_W];
    logic [WF-1:0]     r_fy [HI_W];
    logic [QW-1:0]     r_num_x;
    logic [QW-1:0]     r_num_y;
    logic [NUM_W-1:0]  w_nx;
    logic [NUM_W-1:0]  w_ny;
    logic [QW-1:0]     w_qx;
    logic [QW-1:0]     w_qy;
    logic [QW-1:0]     w_bx;
    logic [QW-1:0]     w_by;
    logic [LS_W-1:0]   w_x1;
    logic [LS_W-1:0]   w_y1;
    logic              r_av;
    t_task             r_task;
    t_task             n_task;

    // stall everything only when a finished task cannot enter the queue
    assign w_en    = !(r_av && i_full);
    assign o_ready = w_en;
    assign o_push  = r_av && !i_full;
    assign o_task  = r_task;

    assign w_nx = {i_item.pixel_x, 1'b1} * i_cfg.lm_w;
    assign w_ny = {i_item.pixel_y, 1'b1} * i_cfg.lm_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_av  <= 1'b0;
        end else if (w_en) begin
            r_vld <= {r_vld[PL_LEN-2:0], i_valid};
            r_av  <= r_vld[PL_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pl[0] <= i_item;
            for (int k = 1; k < PL_LEN; k++) begin
                r_pl[k] <= r_pl[k-1];
            end
            r_num_x <= {w_nx, {(WF-1){1'b0}}};
            r_num_y <= {w_ny, {(WF-1){1'b0}}};
            r_fx[0] <= w_bx[WF-1:0];
            r_fy[0] <= w_by[WF-1:0];
            for (int k = 1; k < HI_W; k++) begin
                r_fx[k] <= r_fx[k-1];
                r_fy[k] <= r_fy[k-1];
            end
            r_task <= n_task;
        end
    end

    lbm_div #(.NW(QW), .DW(AS_W)) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_num_x),
        .i_den (i_cfg.al_w),
        .o_quo (w_qx),
        .o_rem ()
    );

    lbm_div #(.NW(QW), .DW(AS_W)) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_num_y),
        .i_den (i_cfg.al_h),
        .o_quo (w_qy),
        .o_rem ()
    );

    // shift by half a texel; upper bits give the right/lower neighbor
    assign w_bx = w_qx + QW'(1 << (WF - 1));
    assign w_by = w_qy + QW'(1 << (WF - 1));

    lbm_div #(.NW(HI_W), .DW(LS_W)) u_wrap_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_bx[QW-1:WF]),
        .i_den (i_cfg.lm_w),
        .o_quo (),
        .o_rem (w_x1)
    );

    lbm_div #(.NW(HI_W), .DW(LS_W)) u_wrap_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_by[QW-1:WF]),
        .i_den (i_cfg.lm_h),
        .o_quo (),
        .o_rem (w_y1)
    );

    always_comb begin : c_addr
        logic [LS_W-1:0]   v_x0;
        logic [LS_W-1:0]   v_y0;
        logic [2*LS_W-1:0] v_row0;
        logic [2*LS_W-1:0] v_row1;
        t_in_item          v_it;
        v_it   = r_pl[PL_LEN-1];
        v_x0   = (w_x1 == '0) ? i_cfg.lm_w - 1'b1 : w_x1 - 1'b1;
        v_y0   = (w_y1 == '0) ? i_cfg.lm_h - 1'b1 : w_y1 - 1'b1;
        v_row0 = v_y0 * i_cfg.lm_w;
        v_row1 = w_y1 * i_cfg.lm_w;
        n_task.cmd    = v_it.cmd;
        n_task.bypass = (i_cfg.lm_w == '0) || (i_cfg.lm_h == '0) ||
                        (i_cfg.al_w == '0) || (i_cfg.al_h == '0);
        n_task.addr[TAP_10] = TEX_AW'(v_row0 + {{LS_W{1'b0}}, w_x1});
        n_task.addr[TAP_01] = TEX_AW'(v_row1 + {{LS_W{1'b0}}, v_x0});
        n_task.addr[TAP_11] = TEX_AW'(v_row1 + {{LS_W{1'b0}}, w_x1});
        if (v_it.cmd == CMD_LOAD) begin
            n_task.addr[TAP_00] = v_it.texel_index;
        end else begin
            n_task.addr[TAP_00] = TEX_AW'(v_row0 + {{LS_W{1'b0}}, v_x0});
        end
        n_task.frac_x  = r_fx[HI_W-1];
        n_task.frac_y  = r_fy[HI_W-1];
        n_task.pixel_x = v_it.pixel_x;
        n_task.pixel_y = v_it.pixel_y;
        n_task.red     = v_it.in_red;
        n_task.green   = v_it.in_green;
        n_task.blue    = v_it.in_blue;
        n_task.alpha   = v_it.in_alpha;
    end

endmodule

`default_nettype wire

>>> hw/rtl/lbm_queue.sv
// Short task queue between the front and the back end.
// Uses lbm_pkg for the task type.
`timescale 1ns / 1ps
`default_nettype none

module lbm_queue import lbm_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_task o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_task         r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count above depth");

    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count missed a push");

    a_cnt_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("queue count missed a pop");

    a_ptr_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("queue pointers differ while empty");

endmodule

`default_nettype wire

>>> hw/rtl/lbm_back.sv
// Back end: texel store (two copies, two read ports each), bilinear blend,
// albedo multiply and output register. Uses lbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbm_back import lbm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_task     i_task,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    function automatic logic [15:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                          input logic [WF-1:0] f);
        logic [15:0] v_p0;
        logic [15:0] v_p1;
        v_p0 = {8'd0, a} * (16'd256 - {8'd0, f});
        v_p1 = {8'd0, b} * {8'd0, f};
        return v_p0 + v_p1;
    endfunction

    function automatic logic [23:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                           input logic [WF-1:0] f);
        logic [23:0] v_p0;
        logic [23:0] v_p1;
        v_p0 = {8'd0, a} * (24'd256 - {16'd0, f});
        v_p1 = {8'd0, b} * {16'd0, f};
        return v_p0 + v_p1;
    endfunction

    logic [TEXEL_W-1:0] r_mem_a [TEX_DEPTH];  // rows y0
    logic [TEXEL_W-1:0] r_mem_b [TEX_DEPTH];  // rows y1

    logic               w_en;
    logic               w_load;
    logic [TEXEL_W-1:0] w_wdata;

    // stage 0: store read
    logic               r_v0;
    t_task              r_k0;
    logic [TEXEL_W-1:0] r_t00, r_t10, r_t01, r_t11;
    // stage 1: horizontal blend
    logic               r_v1;
    logic               r_byp1;
    logic [WF-1:0]      r_fy1;
    t_out_item          r_p1;
    logic [15:0]        r_top [3];
    logic [15:0]        r_bot [3];
    logic [15:0]        n_top [3];
    logic [15:0]        n_bot [3];
    // stage 2: vertical blend
    logic               r_v2;
    logic               r_byp2;
    t_out_item          r_p2;
    logic [23:0]        r_blend [3];
    // stage 3: albedo product
    logic               r_v3;
    logic               r_byp3;
    t_out_item          r_p3;
    logic [23:0]        r_prod [3];
    logic [23:0]        n_prod [3];
    // output
    logic               r_ov;
    t_out_item          r_out;
    t_out_item          n_out;

    assign w_en    = !r_ov || i_ready;
    assign o_pop   = i_valid && w_en;
    assign w_load  = o_pop && (i_task.cmd == CMD_LOAD);
    assign w_wdata = {i_task.red, i_task.green, i_task.blue};
    assign o_valid = r_ov;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem_a[i_task.addr[TAP_00]] <= w_wdata;
        end
        if (w_en) begin
            r_t00 <= r_mem_a[i_task.addr[TAP_00]];
            r_t10 <= r_mem_a[i_task.addr[TAP_10]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mem_b[i_task.addr[TAP_00]] <= w_wdata;
        end
        if (w_en) begin
            r_t01 <= r_mem_b[i_task.addr[TAP_01]];
            r_t11 <= r_mem_b[i_task.addr[TAP_11]];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_top[c] = lerp8(r_t00[8*c +: 8], r_t10[8*c +: 8], r_k0.frac_x);
            n_bot[c] = lerp8(r_t01[8*c +: 8], r_t11[8*c +: 8], r_k0.frac_x);
        end
    end

    // index 0 blue, 1 green, 2 red, matching the texel packing
    always_comb begin : c_prod
        logic [23:0] v_l;
        logic [7:0]  v_alb [3];
        v_alb[0] = r_p2.out_blue;
        v_alb[1] = r_p2.out_green;
        v_alb[2] = r_p2.out_red;
        for (int c = 0; c < 3; c++) begin
            v_l       = (r_blend[c] + 24'd128) >> 8;
            n_prod[c] = {16'd0, v_alb[c]} * {8'd0, v_l[15:0]} + 24'd32640;
        end
    end

    // divide by 255*256: drop 8 bits, then divide by 255 exactly
    always_comb begin : c_out
        logic [16:0] v_y;
        logic [16:0] v_q;
        logic [7:0]  v_ch [3];
        for (int c = 0; c < 3; c++) begin
            v_y     = {1'b0, r_prod[c][23:8]};
            v_q     = (v_y + {9'd0, v_y[15:8]} + 17'd1) >> 8;
            v_ch[c] = (v_q > 17'd255) ? 8'd255 : v_q[7:0];
        end
        n_out = r_p3;
        if (!r_byp3) begin
            n_out.out_red   = v_ch[2];
            n_out.out_green = v_ch[1];
            n_out.out_blue  = v_ch[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            // drop loads here: they leave no result
            r_v0 <= i_valid && (i_task.cmd == CMD_MOD);
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k0 <= i_task;

            r_byp1          <= r_k0.bypass;
            r_fy1           <= r_k0.frac_y;
            r_p1.out_x      <= r_k0.pixel_x;
            r_p1.out_y      <= r_k0.pixel_y;
            r_p1.out_red    <= r_k0.red;
            r_p1.out_green  <= r_k0.green;
            r_p1.out_blue   <= r_k0.blue;
            r_p1.out_alpha  <= r_k0.alpha;
            for (int c = 0; c < 3; c++) begin
                r_top[c] <= n_top[c];
                r_bot[c] <= n_bot[c];
            end

            r_byp2 <= r_byp1;
            r_p2   <= r_p1;
            for (int c = 0; c < 3; c++) begin
                r_blend[c] <= lerp16(r_top[c], r_bot[c], r_fy1);
            end

            r_byp3 <= r_byp2;
            r_p3   <= r_p2;
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= n_prod[c];
            end

            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for lightmap_bilinear_modulate: random and directed
// texel loads and pixel modulates checked against a bit-exact predictor.
// Depends on lbm_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
    import lbm_pkg::*;

    class pixel_scoreboard;
        bit [23:0]   texels [TEX_DEPTH];
        bit          filled [TEX_DEPTH];
        int unsigned lm_w, lm_h, al_w, al_h;
        t_out_item   pixel_q[$];
        int          fails;

        function new();
            lm_w = 0; lm_h = 0; al_w = 1; al_h = 1; fails = 0;
        endfunction

        function int pending_count();
            return pixel_q.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [AS_W-1:0] val);
            int unsigned side;
            side = (val > MAX_ALBEDO_SIDE) ? MAX_ALBEDO_SIDE : val;
            case (idx)
                CFG_LM_W: lm_w = val[7:0];
                CFG_LM_H: lm_h = val[7:0];
                CFG_AL_W: al_w = side;
                default:  al_h = side;
            endcase
        endfunction

        function void map_axis(int unsigned p, lsz, asz,
                               output int unsigned i0, i1, frac);
            longint unsigned q, b, hi;
            q = ((longint'(2 * p + 1) * lsz) << WF) / (2 * longint'(asz));
            b = q + (1 << (WF - 1));
            hi = b >> WF;
            i1 = hi % lsz;
            i0 = (hi + lsz - 1) % lsz;
            frac = b & ((1 << WF) - 1);
        endfunction

        // Give the four store addresses a pixel samples; 0 when it passes through.
        function bit sample_taps(int unsigned px, py, output int unsigned addr[4],
                                 output int unsigned fx, fy);
            int unsigned x0, x1, y0, y1;
            if (lm_w == 0 || lm_h == 0 || al_w == 0 || al_h == 0) return 0;
            map_axis(px, lm_w, al_w, x0, x1, fx);
            map_axis(py, lm_h, al_h, y0, y1, fy);
            addr[TAP_00] = (y0 * lm_w + x0) % TEX_DEPTH;
            addr[TAP_10] = (y0 * lm_w + x1) % TEX_DEPTH;
            addr[TAP_01] = (y1 * lm_w + x0) % TEX_DEPTH;
            addr[TAP_11] = (y1 * lm_w + x1) % TEX_DEPTH;
            return 1;
        endfunction

        function logic [7:0] shade(longint unsigned alb, c00, c10, c01, c11, fx, fy);
            longint unsigned top, bot, v, l, r;
            top = c00 * (256 - fx) + c10 * fx;
            bot = c01 * (256 - fx) + c11 * fx;
            v = top * (256 - fy) + bot * fy;
            l = (v + 128) >> 8;
            r = (alb * l + 255 * 128) / (255 * 256);
            return (r > 255) ? 8'd255 : r[7:0];
        endfunction

        function void note_input(t_in_item it);
            t_out_item   res;
            int unsigned a[4];
            int unsigned fx, fy;
            bit [23:0]   t[4];
            if (it.cmd == CMD_LOAD) begin
                texels[it.texel_index] = {it.in_red, it.in_green, it.in_blue};
                filled[it.texel_index] = 1;
                return;
            end
            res = '{it.pixel_x, it.pixel_y, it.in_red, it.in_green, it.in_blue, it.in_alpha};
            if (sample_taps(it.pixel_x, it.pixel_y, a, fx, fy)) begin
                foreach (t[k]) t[k] = texels[a[k]];
                res.out_red   = shade(it.in_red, t[0][23:16], t[1][23:16],
                                      t[2][23:16], t[3][23:16], fx, fy);
                res.out_green = shade(it.in_green, t[0][15:8], t[1][15:8],
                                      t[2][15:8], t[3][15:8], fx, fy);
                res.out_blue  = shade(it.in_blue, t[0][7:0], t[1][7:0],
                                      t[2][7:0], t[3][7:0], fx, fy);
            end
            pixel_q.push_back(res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pixel_q.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected pixel %h", got);
                return;
            end
            want = pixel_q.pop_front();
            if (got !== want) begin
                fails++;
                if (fails <= 10) begin
                    $display("pixel mismatch: want x=%0d y=%0d rgba=%h %h %h %h",
                             want.out_x, want.out_y, want.out_red, want.out_green,
                             want.out_blue, want.out_alpha);
                    $display("                got  x=%0d y=%0d rgba=%h %h %h %h",
                             got.out_x, got.out_y, got.out_red, got.out_green,
                             got.out_blue, got.out_alpha);
                end
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    t_in_item        i_in_data;
    logic            o_out_valid;
    logic            i_out_ready;
    t_out_item       o_out_data;
    logic            i_cfg_wr_en;
    logic [1:0]      i_cfg_index;
    logic [AS_W-1:0] i_cfg_data;

    pixel_scoreboard sb = new();
    bit              gaps_on;
    bit              stalls_on;
    bit              hold_req;
    int              burst_left;
    int              cycles;

    lightmap_bilinear_modulate dut (.*);

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1000000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: own stall pattern plus one long hold-off on request.
    initial begin : receiver
        int hold_cnt;
        hold_cnt = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 0;
                hold_cnt = 400;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !stalls_on || ($urandom_range(0, 3) != 0);
            end
        end
    end

    task automatic send_beat(t_in_item it);
        int gap;
        gap = 0;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
    endtask

    task automatic send_load(int unsigned idx, bit [23:0] rgb);
        t_in_item it;
        it = {$urandom, $urandom};
        it.cmd = CMD_LOAD;
        it.texel_index = idx;
        {it.in_red, it.in_green, it.in_blue} = rgb;
        send_beat(it);
    endtask

    // Load any sampled texel not yet written, then the pixel.
    task automatic send_pixel(int unsigned px, py, bit [31:0] rgba);
        t_in_item    it;
        int unsigned a[4];
        int unsigned fx, fy;
        if (sb.sample_taps(px, py, a, fx, fy))
            foreach (a[k]) if (!sb.filled[a[k]]) send_load(a[k], $urandom);
        it = {$urandom, $urandom};
        it.cmd = CMD_MOD;
        it.pixel_x = px;
        it.pixel_y = py;
        {it.in_red, it.in_green, it.in_blue, it.in_alpha} = rgba;
        send_beat(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic configure(int unsigned lw, lh, aw, ah);
        logic [AS_W-1:0] vals[4];
        drain();
        vals = '{lw, lh, aw, ah};
        foreach (vals[k]) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= k;
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            sb.set_reg(k, vals[k]);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int unsigned px, py;
        repeat (n) begin
            if ($urandom_range(0, 9) < 3) begin
                send_load($urandom_range(0, TEX_DEPTH - 1), $urandom);
            end else begin
                if ($urandom_range(0, 1) && sb.al_w != 0 && sb.al_h != 0) begin
                    px = $urandom_range(0, sb.al_w - 1);
                    py = $urandom_range(0, sb.al_h - 1);
                end else begin
                    px = $urandom_range(0, 4095);
                    py = $urandom_range(0, 4095);
                end
                send_pixel(px, py, $urandom);
            end
        end
    endtask

    initial begin : stimulus
        int unsigned lw, lh, aw, ah;
        cycles = 0;
        hold_req = 0;
        gaps_on = 0;
        stalls_on = 0;
        burst_left = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_LM_W;
        i_cfg_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config passes pixels through, then a 4x4 lightmap, zero sides and large or clamped sides
        send_pixel(4095, 4095, 32'hFFFFFFFF);
        send_load(TEX_DEPTH - 1, 24'hFFFFFF);
        configure(4, 4, 8, 8);
        send_load(0, 24'h000000);
        send_load(5, 24'hFFFFFF);
        send_pixel(0, 0, 32'hFFFFFFFF);
        send_pixel(7, 7, 32'h00000000);
        send_pixel(2, 3, 32'hFF80FF01);
        send_pixel(4095, 0, 32'hFFFFFF00);
        configure(0, 4, 8, 8);
        send_pixel(1, 1, 32'h12345678);
        configure(4, 0, 8, 8);
        send_pixel(1, 1, 32'h9ABCDEF0);
        configure(4, 4, 0, 8);
        send_pixel(3, 3, 32'hFFFFFFFF);
        configure(128, 128, 8191, 4096);
        send_pixel(4095, 4095, 32'hFFFFFFFF);
        send_pixel(0, 0, 32'hFFFFFFFF);
        configure(255, 255, 1, 1);
        send_pixel(0, 0, 32'hFFFFFFFF);

        // random phases over a spread of settings
        gaps_on = 1;
        stalls_on = 1;
        configure(1, 1, 1, 1);
        random_phase(60);
        configure(128, 128, 4096, 4096);
        random_phase(100);
        configure(3, 5, 7, 2);
        stalls_on = 0;
        gaps_on = 0;
        hold_req = 1;
        random_phase(100);
        drain();
        gaps_on = 1;
        stalls_on = 1;
        configure(255, 200, 4096, 1);
        random_phase(80);
        configure(128, 0, 100, 100);
        random_phase(30);
        repeat (6) begin
            lw = $urandom_range(0, 255);
            lh = $urandom_range(1, 255);
            aw = $urandom_range(0, 8191);
            ah = $urandom_range(1, 8191);
            configure(lw, lh, aw, ah);
            gaps_on = $urandom_range(0, 1);
            stalls_on = $urandom_range(0, 1);
            random_phase(50);
        end

        drain();
        if (sb.fails == 0 && sb.pending_count() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/lbm_pkg.sv
hw/rtl/lbm_div.sv
hw/rtl/lbm_front.sv
hw/rtl/lbm_queue.sv
hw/rtl/lbm_back.sv
hw/rtl/lightmap_bilinear_modulate.sv
verif/testbench.sv
